### design/lcuf_pkg.sv
package lcuf_pkg;

    localparam logic [7:0]  PKT_TYPE_COMMAND   = 8'h01;
    localparam logic [15:0] OPCODE_CONN_UPDATE = 16'h2013;
    localparam logic [7:0]  PARAM_LEN          = 8'd14;
    localparam logic [15:0] HANDLE_LIMIT       = 16'h0EFF;
    localparam logic [15:0] INTERVAL_LOW       = 16'd6;
    localparam logic [15:0] INTERVAL_HIGH      = 16'd3200;
    localparam logic [15:0] LATENCY_HIGH       = 16'd499;
    localparam logic [15:0] TIMEOUT_LOW        = 16'd10;
    localparam logic [15:0] TIMEOUT_HIGH       = 16'd3200;

    localparam int          PACKET_LEN = 18;
    localparam logic [4:0]  LAST_POS   = 5'(PACKET_LEN - 1);

    localparam int          QUEUE_DEPTH = 2;

    // One classified request as it waits between the front and the back.
    typedef struct packed {
        logic        ok;
        logic [15:0] conn_handle;
        logic [15:0] interval_min;
        logic [15:0] interval_max;
        logic [15:0] slave_latency;
        logic [15:0] timeout_units;
    } lcuf_req_t;

    typedef struct packed {
        logic push;
        logic full;
    } lcuf_wr_ctl_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } lcuf_rd_ctl_t;

    function automatic logic [7:0] pkt_byte(input logic [4:0] pos, input lcuf_req_t r);
        logic [15:0] word;
        word = 16'h0000;
        unique case (pos[4:1])
            4'd0:    word = {OPCODE_CONN_UPDATE[7:0], PKT_TYPE_COMMAND};
            4'd1:    word = {PARAM_LEN, OPCODE_CONN_UPDATE[15:8]};
            4'd2:    word = r.conn_handle;
            4'd3:    word = r.interval_min;
            4'd4:    word = r.interval_max;
            4'd5:    word = r.slave_latency;
            4'd6:    word = r.timeout_units;
            default: word = 16'h0000;
        endcase
        return pos[0] ? word[15:8] : word[7:0];
    endfunction

endpackage

### design/lcuf_if.sv
interface lcuf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] conn_handle;
    logic [15:0] interval_min;
    logic [15:0] interval_max;
    logic [15:0] slave_latency;
    logic [15:0] timeout_units;

    modport source (
        output valid, conn_handle, interval_min, interval_max, slave_latency, timeout_units,
        input  ready
    );
    modport sink (
        input  valid, conn_handle, interval_min, interval_max, slave_latency, timeout_units,
        output ready
    );
endinterface

interface lcuf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;
    logic       rejected;

    modport source (
        output valid, packet_byte, last_byte, rejected,
        input  ready
    );
    modport sink (
        input  valid, packet_byte, last_byte, rejected,
        output ready
    );
endinterface

### design/lcuf_front.sv
module lcuf_front (
    lcuf_in_if.sink               req,
    input  logic                  q_full,
    output lcuf_pkg::lcuf_wr_ctl_t wr_ctl,
    output lcuf_pkg::lcuf_req_t   q_entry
);
    import lcuf_pkg::*;

    logic        limits_ok;
    logic [9:0]  latency_plus_one;
    logic [21:0] event_span;
    logic [21:0] timeout_x4;

    // The timeout test is halved on both sides: timeout * 4 > (1 + latency) * max.
    // The narrow operands are exact once the range checks have passed.
    assign latency_plus_one = {1'b0, req.slave_latency[8:0]} + 10'd1;
    assign event_span       = 22'(latency_plus_one) * 22'(req.interval_max[11:0]);
    assign timeout_x4       = {4'b0000, req.timeout_units, 2'b00};

    assign limits_ok = (req.conn_handle <= HANDLE_LIMIT)
                    && (req.interval_min >= INTERVAL_LOW)
                    && (req.interval_max <= INTERVAL_HIGH)
                    && (req.interval_min <= req.interval_max)
                    && (req.slave_latency <= LATENCY_HIGH)
                    && (req.timeout_units >= TIMEOUT_LOW)
                    && (req.timeout_units <= TIMEOUT_HIGH)
                    && (timeout_x4 > event_span);

    assign req.ready   = !q_full;
    assign wr_ctl.push = req.valid && !q_full;
    assign wr_ctl.full = q_full;

    assign q_entry.ok            = limits_ok;
    assign q_entry.conn_handle   = req.conn_handle;
    assign q_entry.interval_min  = req.interval_min;
    assign q_entry.interval_max  = req.interval_max;
    assign q_entry.slave_latency = req.slave_latency;
    assign q_entry.timeout_units = req.timeout_units;
endmodule

### design/lcuf_queue.sv
module lcuf_queue #(
    parameter int DEPTH = lcuf_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lcuf_pkg::lcuf_req_t    wdata,
    output logic                   full,
    input  logic                   pop,
    output logic                   empty,
    output lcuf_pkg::lcuf_req_t    rdata
);
    import lcuf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcuf_req_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end
endmodule

### design/lcuf_back.sv
module lcuf_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcuf_pkg::lcuf_req_t    q_entry,
    output lcuf_pkg::lcuf_rd_ctl_t rd_ctl,
    input  logic                   q_empty,
    lcuf_out_if.source             pkt
);
    import lcuf_pkg::*;

    lcuf_req_t  cur_reg;
    logic       busy_reg, busy_next;
    logic [4:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       rej_reg;
    logic       adv;
    logic       cur_last;
    logic       pop;

    // A rejected request is a single word; a good one runs to the final position.
    assign adv      = busy_reg && (!out_valid_reg || pkt.ready);
    assign cur_last = !cur_reg.ok || (pos_reg == LAST_POS);
    assign pop      = !q_empty && (!busy_reg || (adv && cur_last));

    assign rd_ctl.pop   = pop;
    assign rd_ctl.empty = q_empty;

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (pkt.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (adv)
        begin
            out_valid_next = 1'b1;
            pos_next       = cur_last ? 5'd0 : pos_reg + 5'd1;
            if (cur_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_entry;
        end
        if (adv)
        begin
            byte_reg <= cur_reg.ok ? pkt_byte(pos_reg, cur_reg) : 8'h00;
            last_reg <= cur_last;
            rej_reg  <= !cur_reg.ok;
        end
    end

    assign pkt.valid       = out_valid_reg;
    assign pkt.packet_byte = byte_reg;
    assign pkt.last_byte   = last_reg;
    assign pkt.rejected    = rej_reg;
endmodule

### design/le_conn_update_command_framer.sv
// Channel  Role    Word
// req      sink    one connection update request (handle, intervals, latency, timeout)
// pkt      source  one command byte with last and rejected marks
//
// A good request becomes 18 words on pkt, one per cycle while pkt is ready; a rejected
// one is one word. The byte serializer sets the rate. The limit check and a two-entry
// queue sit ahead of it, so req keeps taking words while a packet is still being sent;
// a request passes the queue slot, cur_reg and the output register before pkt shows it.
// Reset clears the queue, the serializer and the output register; no clearing pass.
// A stall on pkt holds the current byte; req stalls only once the queue is full.
module le_conn_update_command_framer #(
    parameter int QUEUE_DEPTH = lcuf_pkg::QUEUE_DEPTH
) (
    input logic        clk,
    input logic        rst_n,
    lcuf_in_if.sink    req,
    lcuf_out_if.source pkt
);
    import lcuf_pkg::*;

    lcuf_wr_ctl_t wr_ctl;
    lcuf_rd_ctl_t rd_ctl;
    lcuf_req_t    front_entry;
    lcuf_req_t    back_entry;
    logic         q_full;
    logic         q_empty;

    lcuf_front u_front (
        .req     (req),
        .q_full  (q_full),
        .wr_ctl  (wr_ctl),
        .q_entry (front_entry)
    );

    lcuf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (wr_ctl.push),
        .wdata (front_entry),
        .full  (q_full),
        .pop   (rd_ctl.pop),
        .empty (q_empty),
        .rdata (back_entry)
    );

    lcuf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_entry (back_entry),
        .rd_ctl  (rd_ctl),
        .q_empty (q_empty),
        .pkt     (pkt)
    );

    a_reject_is_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.valid && pkt.rejected |-> pkt.last_byte && (pkt.packet_byte == 8'h00))
        else $error("rejected word is not a single zero word");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> q_full)
        else $error("request side stalled with room in the queue");

    a_packet_not_interrupted: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.valid && pkt.ready && !pkt.last_byte |=> !pkt.rejected)
        else $error("rejection appeared inside a packet");

    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rd_ctl.pop |-> !rd_ctl.empty)
        else $error("serializer took a word from an empty queue");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ctl.push |-> !wr_ctl.full)
        else $error("front pushed a word into a full queue");
endmodule

### tb/tb_le_conn_update_command_framer.sv
module tb_le_conn_update_command_framer;
    timeunit 1ns;
    timeprecision 1ps;

    import lcuf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 23;
    localparam int RANDOM_ITEMS = 280;

    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] ival_min;
        logic [15:0] ival_max;
        logic [15:0] latency;
        logic [15:0] timeout;
    } conn_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       rej;
    } cmd_word_t;

    // Predicts the command words for each accepted request and checks the
    // words that leave the block against them in order.
    class update_scoreboard;
        cmd_word_t   expected_q[$];
        int unsigned mismatches;
        conn_req_t   held;

        function new();
            mismatches = 0;
            held       = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit limits_hold(conn_req_t r);
            logic [63:0] budget;
            logic [63:0] demand;
            if (r.handle > HANDLE_LIMIT) return 1'b0;
            if (r.ival_min < INTERVAL_LOW || r.ival_max > INTERVAL_HIGH) return 1'b0;
            if (r.ival_min > r.ival_max) return 1'b0;
            if (r.latency > LATENCY_HIGH) return 1'b0;
            if (r.timeout < TIMEOUT_LOW || r.timeout > TIMEOUT_HIGH) return 1'b0;
            budget = 64'(r.timeout) * 64'd8;
            demand = (64'd1 + 64'(r.latency)) * 64'(r.ival_max) * 64'd2;
            return budget > demand;
        endfunction

        function void note_request(conn_req_t r);
            logic [7:0] frame [PACKET_LEN];
            cmd_word_t  w;
            if (!limits_hold(r))
            begin
                w.data = 8'h00;
                w.last = 1'b1;
                w.rej  = 1'b1;
                expected_q.push_back(w);
                return;
            end
            held = r;
            frame[0]  = PKT_TYPE_COMMAND;
            frame[1]  = OPCODE_CONN_UPDATE[7:0];
            frame[2]  = OPCODE_CONN_UPDATE[15:8];
            frame[3]  = PARAM_LEN;
            frame[4]  = held.handle[7:0];
            frame[5]  = held.handle[15:8];
            frame[6]  = held.ival_min[7:0];
            frame[7]  = held.ival_min[15:8];
            frame[8]  = held.ival_max[7:0];
            frame[9]  = held.ival_max[15:8];
            frame[10] = held.latency[7:0];
            frame[11] = held.latency[15:8];
            frame[12] = held.timeout[7:0];
            frame[13] = held.timeout[15:8];
            // Both connection event lengths are sent as zero.
            for (int k = 14; k < PACKET_LEN; k++) frame[k] = 8'h00;
            for (int k = 0; k < PACKET_LEN; k++)
            begin
                w.data = frame[k];
                w.last = (k == PACKET_LEN - 1);
                w.rej  = 1'b0;
                expected_q.push_back(w);
            end
        endfunction

        function void check_word(cmd_word_t got);
            cmd_word_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected word: byte %h last %b rejected %b",
                         $time, got.data, got.last, got.rej);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.data !== want.data)
            begin
                $display("%0t: packet_byte expected %h actual %h", $time, want.data, got.data);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last_byte expected %b actual %b", $time, want.last, got.last);
                mismatches++;
            end
            if (got.rej !== want.rej)
            begin
                $display("%0t: rejected expected %b actual %b", $time, want.rej, got.rej);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   cycle_count;

    update_scoreboard sb;

    lcuf_in_if  req_if ();
    lcuf_out_if pkt_if ();

    le_conn_update_command_framer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .pkt   (pkt_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cmd_word_t got;
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                sb.note_request({req_if.conn_handle, req_if.interval_min, req_if.interval_max,
                                 req_if.slave_latency, req_if.timeout_units});
            if (pkt_if.valid && pkt_if.ready)
            begin
                got.data = pkt_if.packet_byte;
                got.last = pkt_if.last_byte;
                got.rej  = pkt_if.rejected;
                sb.check_word(got);
            end
        end
    end

    // The result side stalls at random except while calm is set.
    initial
    begin
        pkt_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            pkt_if.ready = calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[le_conn_update_command_framer] ERROR");
        $finish;
    end

    function automatic conn_req_t make_req(int h, int imin, int imax, int lat, int tmo);
        conn_req_t r;
        r.handle   = 16'(h);
        r.ival_min = 16'(imin);
        r.ival_max = 16'(imax);
        r.latency  = 16'(lat);
        r.timeout  = 16'(tmo);
        return r;
    endfunction

    // A request that passes every limit, with random content.
    function automatic conn_req_t well_formed();
        conn_req_t r;
        int        n;
        r.handle   = 16'($urandom_range(0, HANDLE_LIMIT));
        r.ival_max = 16'($urandom_range(INTERVAL_LOW, INTERVAL_HIGH));
        r.ival_min = 16'($urandom_range(INTERVAL_LOW, r.ival_max));
        r.timeout  = 16'($urandom_range(TIMEOUT_LOW, TIMEOUT_HIGH));
        // Latency is chosen so that timeout * 4 > (1 + latency) * max, as the front tests.
        n = (int'(r.timeout) * 4 - 1) / int'(r.ival_max);
        if (n == 0)
        begin
            r.timeout = TIMEOUT_HIGH;
            n = (int'(r.timeout) * 4 - 1) / int'(r.ival_max);
        end
        if (n - 1 > LATENCY_HIGH) n = LATENCY_HIGH + 1;
        r.latency = 16'($urandom_range(0, n - 1));
        return r;
    endfunction

    // Pushes one field of a good request past a limit.
    function automatic conn_req_t broken();
        conn_req_t r;
        r = well_formed();
        case ($urandom_range(0, 7))
            0: r.handle   = 16'($urandom_range(HANDLE_LIMIT + 1, 16'hFFFF));
            1: r.ival_min = 16'($urandom_range(0, INTERVAL_LOW - 1));
            2: r.ival_max = 16'($urandom_range(INTERVAL_HIGH + 1, 16'hFFFF));
            3: r.ival_min = r.ival_max + 16'($urandom_range(1, 40));
            4: r.latency  = 16'($urandom_range(LATENCY_HIGH + 1, 16'hFFFF));
            5: r.timeout  = 16'($urandom_range(0, TIMEOUT_LOW - 1));
            6: r.timeout  = 16'($urandom_range(TIMEOUT_HIGH + 1, 16'hFFFF));
            default: r.latency = 16'((int'(r.timeout) * 4 - 1) / int'(r.ival_max));
        endcase
        return r;
    endfunction

    task automatic send_request(input conn_req_t r);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid         = 1'b1;
        req_if.conn_handle   = r.handle;
        req_if.interval_min  = r.ival_min;
        req_if.interval_max  = r.ival_max;
        req_if.slave_latency = r.latency;
        req_if.timeout_units = r.timeout;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_packets();
        req_if.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    initial
    begin
        conn_req_t directed [$];
        int        pick;

        sb   = new();
        calm = 1'b0;
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.conn_handle   = '0;
        req_if.interval_min  = '0;
        req_if.interval_max  = '0;
        req_if.slave_latency = '0;
        req_if.timeout_units = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed.push_back(make_req(0, 6, 6, 0, 10));
        directed.push_back(make_req(16'h0EFF, 3200, 3200, 2, 3200));
        directed.push_back(make_req(16'h0EFF, 3200, 3200, 3, 3200));
        directed.push_back(make_req(16'h0F00, 100, 200, 0, 500));
        directed.push_back(make_req(16'hFFFF, 100, 200, 0, 500));
        directed.push_back(make_req(1, 5, 200, 0, 500));
        directed.push_back(make_req(1, 100, 3201, 0, 3200));
        directed.push_back(make_req(1, 100, 99, 0, 500));
        directed.push_back(make_req(2, 6, 6, 499, 3200));
        directed.push_back(make_req(2, 6, 6, 500, 3200));
        directed.push_back(make_req(2, 6, 6, 16'hFFFF, 3200));
        directed.push_back(make_req(3, 6, 6, 0, 9));
        directed.push_back(make_req(3, 6, 6, 0, 3201));
        directed.push_back(make_req(3, 6, 6, 0, 16'hFFFF));
        // Timeout exactly equal to the required span, then one unit above it.
        directed.push_back(make_req(4, 40, 40, 0, 10));
        directed.push_back(make_req(4, 40, 40, 0, 11));
        directed.push_back(make_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed.push_back(make_req(0, 0, 0, 0, 0));
        directed.push_back(make_req(16'h0AAA, 16'h0555, 16'h0AAA, 3, 16'h0C80));
        directed.push_back(make_req(16'h0555, 16'h0AAA, 16'h0AAA, 0, 16'h0AAA));
        foreach (directed[i]) send_request(directed[i]);

        // The sender holds off here until every word has come out.
        drain_packets();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 60 && i < 120);
            if (i == 180) drain_packets();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_request(well_formed());
            else if (pick < 85)
                send_request(broken());
            else
                send_request(make_req($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                                      $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                                      $urandom_range(0, 16'hFFFF)));
        end
        calm = 1'b0;

        drain_packets();
        repeat (8) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[le_conn_update_command_framer] OK");
        else
            $display("[le_conn_update_command_framer] ERROR");
        $finish;
    end

endmodule

### le_conn_update_command_framer.f
design/lcuf_pkg.sv
design/lcuf_if.sv
design/lcuf_front.sv
design/lcuf_queue.sv
design/lcuf_back.sv
design/le_conn_update_command_framer.sv
tb/tb_le_conn_update_command_framer.sv
